// ----- hw/rtl/slcp_pkg.sv -----
// Shared types, constants and elaboration-time threshold and re-encoding tables for the sRGB/linear color packer.
package slcp_pkg;

    localparam int FLT_W  = 32;
    localparam int BYTE_W = 8;
    localparam int MAG_W  = FLT_W - 1;
    localparam int N_LVL  = 1 << BYTE_W;
    localparam int N_STG  = BYTE_W;
    localparam int BIG_W  = 384;

    typedef logic [BYTE_W-1:0]             t_byte;
    typedef logic [MAG_W-1:0]              t_mag;
    typedef logic [BIG_W-1:0]              t_big;
    typedef logic [N_LVL-1:0][MAG_W-1:0]   t_thr_tab;
    typedef logic [N_LVL-1:0][BYTE_W-1:0]  t_byte_tab;

    typedef enum logic {
        ACT_PACK  = 1'b0,
        ACT_REENC = 1'b1
    } t_action;

    // One search beat: either a bypassed byte or a magnitude to rank.
    typedef struct packed {
        logic  srgb;
        logic  byp;
        t_byte acc;
        t_mag  mag;
    } t_srch;

    localparam t_mag  MAG_ONE  = 31'h3F80_0000;
    localparam t_byte BYTE_MAX = 8'hFF;

    function automatic t_big big_pow(input t_big base, input int n);
        t_big r;
        int   i;
        r = t_big'(1);
        for (i = 0; i < n; i++) begin
            r = r * base;
        end
        return r;
    endfunction

    // v = p / (qm * 2^qs): does the power curve reach byte k?
    function automatic logic enc_ge(input t_big p, input t_big qm, input int qs, input int k);
        t_big l;
        t_big r;
        l = big_pow(p, 5) * big_pow(t_big'(53805), 12);
        r = (big_pow(t_big'(200 * k + 2705), 12) * big_pow(qm, 5)) << (5 * qs);
        return l >= r;
    endfunction

    // sRGB byte b above the linear segment: does its linear value reach byte k?
    function automatic logic dec_ge(input int b, input int k);
        t_big l;
        t_big r;
        l = big_pow(t_big'(40 * b + 561), 12) * big_pow(t_big'(510), 5);
        r = big_pow(t_big'(2 * k - 1), 5) * big_pow(t_big'(10761), 12);
        return l >= r;
    endfunction

    // Positive binary32 magnitude below one: does it encode to byte k or more?
    function automatic logic flt_ge(input t_mag mag, input int k, input logic srgb);
        t_big m;
        int   s;
        if (mag[MAG_W-1:23] != '0) begin
            m = t_big'({1'b1, mag[22:0]});
            s = 150 - int'(mag[MAG_W-1:23]);
        end else begin
            m = t_big'(mag[22:0]);
            s = 149;
        end
        if (!srgb) begin
            return (m * 510) >= (t_big'(2 * k - 1) << s);
        end
        if ((m * 10000000) <= (t_big'(31308) << s)) begin
            return (m * 32946) >= (t_big'(5 * (2 * k - 1)) << s);
        end
        return enc_ge(m, t_big'(1), s, k);
    endfunction

    // Smallest magnitude that encodes to byte k or more.
    function automatic t_mag flt_thr(input int k, input logic srgb);
        t_mag lo;
        t_mag hi;
        t_mag mid;
        lo = '0;
        hi = MAG_ONE;
        while ((hi - lo) > t_mag'(1)) begin
            mid = lo + ((hi - lo) >> 1);
            if (flt_ge(mid, k, srgb)) begin
                hi = mid;
            end else begin
                lo = mid;
            end
        end
        return hi;
    endfunction

    function automatic t_thr_tab mk_thr(input logic srgb);
        t_thr_tab t;
        int       k;
        t[0] = '0;
        for (k = 1; k < N_LVL; k++) begin
            t[k] = flt_thr(k, srgb);
        end
        return t;
    endfunction

    function automatic t_byte s2l_byte(input int b);
        int lo;
        int hi;
        int mid;
        if (b <= 10) begin
            return t_byte'((100 * b + 646) / 1292);
        end
        lo = 0;
        hi = N_LVL - 1;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (dec_ge(b, mid)) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        return t_byte'(lo);
    endfunction

    function automatic t_byte l2s_byte(input int b);
        int lo;
        int hi;
        int mid;
        if (b == 0) begin
            return '0;
        end
        lo = 0;
        hi = N_LVL - 1;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (enc_ge(t_big'(b), t_big'(255), 0, mid)) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        return t_byte'(lo);
    endfunction

    function automatic t_byte_tab mk_s2l();
        t_byte_tab t;
        int        b;
        for (b = 0; b < N_LVL; b++) begin
            t[b] = s2l_byte(b);
        end
        return t;
    endfunction

    function automatic t_byte_tab mk_l2s();
        t_byte_tab t;
        int        b;
        for (b = 0; b < N_LVL; b++) begin
            t[b] = l2s_byte(b);
        end
        return t;
    endfunction

    localparam t_thr_tab  LIN_THR  = mk_thr(1'b0);
    localparam t_thr_tab  SRGB_THR = mk_thr(1'b1);
    localparam t_byte_tab S2L_TAB  = mk_s2l();
    localparam t_byte_tab L2S_TAB  = mk_l2s();

endpackage

// ----- hw/rtl/slcp_lane.sv -----
// One conversion lane: pipelined binary search of a float magnitude over the byte thresholds.
module slcp_lane import slcp_pkg::*; (
    input  logic  i_clk,
    input  t_srch i_cmd,
    output t_byte o_byte
);

    t_srch s_in  [N_STG];
    t_srch n_st  [N_STG];
    t_srch r_st  [N_STG];

    assign s_in[0] = i_cmd;

    for (genvar j = 0; j < N_STG; j++) begin : g_stg
        localparam t_byte STEP = t_byte'(1) << (BYTE_W - 1 - j);

        t_byte probe;
        t_mag  thr;

        if (j > 0) begin : g_link
            assign s_in[j] = r_st[j-1];
        end

        always_comb begin
            probe   = s_in[j].acc | STEP;
            thr     = s_in[j].srgb ? SRGB_THR[probe] : LIN_THR[probe];
            n_st[j] = s_in[j];
            if (!s_in[j].byp && (thr <= s_in[j].mag)) begin
                n_st[j].acc = probe;
            end
        end

        always_ff @(posedge i_clk) begin
            r_st[j] <= n_st[j];
        end
    end

    assign o_byte = r_st[N_STG-1].acc;

endmodule

// ----- hw/rtl/srgb_linear_color_packer.sv -----
// Top level of the sRGB/linear RGBA8 color packer: input decode, four lanes, output merge.
//
// Input channel: a beat is taken at a rising edge with i_start high and o_busy low.
// o_busy is always low, so one pixel can be taken on every clock.
// i_action selects packing from binary32 channels or re-encoding of bytes from the
// other encoding; i_alpha_present forces alpha to 255 when low (pack only).
// Configuration: i_cfg_we writes i_cfg_wdata into the target-encoding bit
// (0 linear, 1 sRGB); it is sampled per beat as the beat enters.
// Result channel: o_done is high for one cycle with the four bytes on o_*_out,
// once the beat has passed the eight-stage threshold search in each lane and the
// output register; throughput is one pixel per clock, red, green, blue and alpha
// each in a lane of its own.
// The receiver cannot stall; every result is shown once, in order.
// Reset (i_rst_n low at an edge) clears the target bit to linear and drops all
// beats in flight.
module srgb_linear_color_packer import slcp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    input  logic             i_start,
    output logic             o_busy,
    input  logic             i_action,
    input  logic [FLT_W-1:0] i_red_in,
    input  logic [FLT_W-1:0] i_green_in,
    input  logic [FLT_W-1:0] i_blue_in,
    input  logic [FLT_W-1:0] i_alpha_in,
    input  logic             i_alpha_present,
    output logic             o_done,
    output t_byte            o_red_out,
    output t_byte            o_green_out,
    output t_byte            o_blue_out,
    output t_byte            o_alpha_out
);

    localparam int N_LANE   = 4;
    localparam int N_COLOR  = 3;
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;
    localparam int CH_ALPHA = 3;

    function automatic logic flt_forced_zero(input logic [FLT_W-1:0] b);
        return b[FLT_W-1] || ((b[FLT_W-2:23] == '1) && (b[22:0] != '0));
    endfunction

    logic             r_srgb;
    logic             n_srgb;
    logic [N_STG-1:0] r_vld;
    logic [N_STG-1:0] n_vld;
    logic             r_done;
    logic             accept;

    logic [FLT_W-1:0] in_bits   [N_LANE];
    t_srch            lane_cmd  [N_LANE];
    t_byte            lane_byte [N_LANE];
    t_byte            r_byte    [N_LANE];

    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;

    assign in_bits[CH_RED]   = i_red_in;
    assign in_bits[CH_GREEN] = i_green_in;
    assign in_bits[CH_BLUE]  = i_blue_in;
    assign in_bits[CH_ALPHA] = i_alpha_in;

    always_comb begin
        for (int i = 0; i < N_COLOR; i++) begin
            lane_cmd[i].srgb = r_srgb;
            lane_cmd[i].mag  = in_bits[i][MAG_W-1:0];
            lane_cmd[i].byp  = 1'b0;
            lane_cmd[i].acc  = '0;
            if (i_action == ACT_REENC) begin
                lane_cmd[i].byp = 1'b1;
                lane_cmd[i].acc = r_srgb ? L2S_TAB[in_bits[i][BYTE_W-1:0]]
                                         : S2L_TAB[in_bits[i][BYTE_W-1:0]];
            end else if (flt_forced_zero(in_bits[i])) begin
                lane_cmd[i].byp = 1'b1;
            end
        end
        lane_cmd[CH_ALPHA].srgb = 1'b0;
        lane_cmd[CH_ALPHA].mag  = in_bits[CH_ALPHA][MAG_W-1:0];
        lane_cmd[CH_ALPHA].byp  = 1'b0;
        lane_cmd[CH_ALPHA].acc  = '0;
        if (i_action == ACT_REENC) begin
            lane_cmd[CH_ALPHA].byp = 1'b1;
            lane_cmd[CH_ALPHA].acc = in_bits[CH_ALPHA][BYTE_W-1:0];
        end else if (!i_alpha_present) begin
            lane_cmd[CH_ALPHA].byp = 1'b1;
            lane_cmd[CH_ALPHA].acc = BYTE_MAX;
        end else if (flt_forced_zero(in_bits[CH_ALPHA])) begin
            lane_cmd[CH_ALPHA].byp = 1'b1;
        end
    end

    for (genvar g = 0; g < N_LANE; g++) begin : g_lane
        slcp_lane u_lane (
            .i_clk  (i_clk),
            .i_cmd  (lane_cmd[g]),
            .o_byte (lane_byte[g])
        );
    end

    assign n_srgb = i_cfg_we ? i_cfg_wdata : r_srgb;
    assign n_vld  = {r_vld[N_STG-2:0], accept};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_srgb <= 1'b0;
            r_vld  <= '0;
            r_done <= 1'b0;
        end else begin
            r_srgb <= n_srgb;
            r_vld  <= n_vld;
            r_done <= r_vld[N_STG-1];
        end
    end

    // merge lane results into the output beat
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < N_LANE; i++) begin
            r_byte[i] <= lane_byte[i];
        end
    end

    assign o_done      = r_done;
    assign o_red_out   = r_byte[CH_RED];
    assign o_green_out = r_byte[CH_GREEN];
    assign o_blue_out  = r_byte[CH_BLUE];
    assign o_alpha_out = r_byte[CH_ALPHA];

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##9 o_done)
        else $error("accepted beat produced no result");

    a_done_caused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, 9))
        else $error("result without an accepted beat");

    a_alpha_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_action == ACT_REENC))
            |-> ##9 (o_alpha_out == $past(i_alpha_in[BYTE_W-1:0], 9)))
        else $error("re-encode alpha not passed through");

    a_red_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_action == ACT_PACK) && i_red_in[FLT_W-1]) |-> ##9 (o_red_out == '0))
        else $error("negative red did not clamp to zero");

endmodule

// ----- tb/sv/srgb_linear_color_packer_tb.sv -----
// Testbench for the sRGB/linear RGBA8 color packer: random and corner pixels against a predictor.
`timescale 1ns / 100ps

module srgb_linear_color_packer_tb;
    import slcp_pkg::*;

    localparam int DRAIN_CYCLES = 12;
    localparam int STALL_LIMIT  = 1000;
    localparam int PHASE_ITEMS  = 150;
    localparam int N_PHASES     = 8;

    typedef logic [511:0] wide_t;

    typedef struct {
        t_action          action;
        logic [FLT_W-1:0] red;
        logic [FLT_W-1:0] green;
        logic [FLT_W-1:0] blue;
        logic [FLT_W-1:0] alpha;
        logic             alpha_on;
    } pixel_in_t;

    typedef struct {
        t_byte red;
        t_byte green;
        t_byte blue;
        t_byte alpha;
    } pixel_out_t;

    logic             i_clk           = 1'b0;
    logic             i_rst_n         = 1'b0;
    logic             i_cfg_we        = 1'b0;
    logic             i_cfg_wdata     = 1'b0;
    logic             i_start         = 1'b0;
    logic             i_action        = 1'b0;
    logic [FLT_W-1:0] i_red_in        = '0;
    logic [FLT_W-1:0] i_green_in      = '0;
    logic [FLT_W-1:0] i_blue_in       = '0;
    logic [FLT_W-1:0] i_alpha_in      = '0;
    logic             i_alpha_present = 1'b0;
    logic             o_busy;
    logic             o_done;
    t_byte            o_red_out;
    t_byte            o_green_out;
    t_byte            o_blue_out;
    t_byte            o_alpha_out;

    pixel_in_t  pending_q[$];
    pixel_out_t expected_q[$];
    pixel_in_t  drv_px;
    pixel_out_t want;
    logic       srgb_mirror = 1'b0;
    int         idle_pct    = 0;
    int         fails       = 0;
    int         stall_cnt   = 0;

    wide_t      knee_pow12[N_LVL];
    wide_t      c53805_pow12;
    t_byte      srgb_to_lin_tab[N_LVL];
    t_byte      lin_to_srgb_tab[N_LVL];

    logic [FLT_W-1:0] corner_bits[11] = '{
        32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
        32'h3F80_0000, 32'h3F7F_FFFF, 32'h0000_0001, 32'h007F_FFFF, 32'h3B4D_2E1C,
        32'h3B4D_2E1D
    };

    logic       phase_tgt[N_PHASES]  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
    int         phase_idle[N_PHASES] = '{0, 48, 0, 32, 0, 48, 32, 0};

    srgb_linear_color_packer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_action        (i_action),
        .i_red_in        (i_red_in),
        .i_green_in      (i_green_in),
        .i_blue_in       (i_blue_in),
        .i_alpha_in      (i_alpha_in),
        .i_alpha_present (i_alpha_present),
        .o_done          (o_done),
        .o_red_out       (o_red_out),
        .o_green_out     (o_green_out),
        .o_blue_out      (o_blue_out),
        .o_alpha_out     (o_alpha_out)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic wide_t wpow(input wide_t base, input int n);
        wide_t r;
        r = wide_t'(1);
        for (int i = 0; i < n; i++) begin
            r = r * base;
        end
        return r;
    endfunction

    // v = p / (qm * 2^qs): does 255*(1.055*v^(1/2.4) - 0.055) reach k - 0.5?
    function automatic logic curve_reaches(input wide_t p, input wide_t qm, input int qs,
                                           input int k);
        wide_t lhs;
        wide_t rhs;
        lhs = wpow(p, 5) * c53805_pow12;
        rhs = (knee_pow12[k] * wpow(qm, 5)) << (5 * qs);
        return lhs >= rhs;
    endfunction

    function automatic t_byte curve_byte(input wide_t p, input wide_t qm, input int qs);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = N_LVL - 1;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (curve_reaches(p, qm, qs, mid)) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        return t_byte'(lo);
    endfunction

    function automatic logic decode_reaches(input int b, input int k);
        wide_t lhs;
        wide_t rhs;
        lhs = wpow(wide_t'(40 * b + 561), 12) * wpow(wide_t'(510), 5);
        rhs = wpow(wide_t'(2 * k - 1), 5) * wpow(wide_t'(10761), 12);
        return lhs >= rhs;
    endfunction

    function automatic t_byte srgb_byte_decode(input int b);
        int lo;
        int hi;
        int mid;
        if (b <= 10) begin
            return t_byte'((100 * b + 646) / 1292);
        end
        lo = 0;
        hi = N_LVL - 1;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (decode_reaches(b, mid)) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        return t_byte'(lo);
    endfunction

    // 0: byte 0, 2: byte 255, 1: 0 < v < 1 with v = m / 2^s
    function automatic int split_float(input logic [31:0] bits, output longint unsigned m,
                                       output int s);
        logic [7:0]  bexp;
        logic [22:0] frac;
        bexp = bits[30:23];
        frac = bits[22:0];
        m = 0;
        s = 0;
        if (bexp == 8'hFF) begin
            return (frac != 0 || bits[31]) ? 0 : 2;
        end
        if (bits[31] || (bexp == 0 && frac == 0)) begin
            return 0;
        end
        if (bexp >= 8'd127) begin
            return 2;
        end
        m = (bexp != 0) ? longint'({1'b1, frac}) : longint'(frac);
        s = (bexp != 0) ? 150 - int'(bexp) : 149;
        return 1;
    endfunction

    function automatic t_byte lin_from_float(input logic [31:0] bits);
        longint unsigned m;
        longint unsigned f;
        int              s;
        int              c;
        c = split_float(bits, m, s);
        if (c != 1) begin
            return (c == 2) ? BYTE_MAX : t_byte'(0);
        end
        f = (s < 64) ? (m * 510) >> s : 0;
        return t_byte'((f + 1) >> 1);
    endfunction

    function automatic t_byte srgb_from_float(input logic [31:0] bits);
        longint unsigned m;
        longint unsigned f;
        int              s;
        int              c;
        c = split_float(bits, m, s);
        if (c != 1) begin
            return (c == 2) ? BYTE_MAX : t_byte'(0);
        end
        if (s > 40 || m * 64'd10000000 <= (64'd31308 << s)) begin
            f = (s < 64) ? (m * 32946) >> s : 0;
            f = f / 5;
            return t_byte'((f + 1) >> 1);
        end
        return curve_byte(wide_t'(m), wide_t'(1), s);
    endfunction

    function automatic pixel_out_t predict_pixel(input pixel_in_t px, input logic tgt);
        pixel_out_t       res;
        logic [FLT_W-1:0] ch[3];
        t_byte            enc[3];
        ch = '{px.red, px.green, px.blue};
        for (int i = 0; i < 3; i++) begin
            if (px.action == ACT_PACK) begin
                enc[i] = tgt ? srgb_from_float(ch[i]) : lin_from_float(ch[i]);
            end else begin
                enc[i] = tgt ? lin_to_srgb_tab[ch[i][7:0]] : srgb_to_lin_tab[ch[i][7:0]];
            end
        end
        res.red   = enc[0];
        res.green = enc[1];
        res.blue  = enc[2];
        if (px.action == ACT_PACK) begin
            res.alpha = px.alpha_on ? lin_from_float(px.alpha) : BYTE_MAX;
        end else begin
            res.alpha = px.alpha[7:0];
        end
        return res;
    endfunction

    function automatic pixel_in_t mk_px(input t_action act, input logic [31:0] r,
                                        input logic [31:0] g, input logic [31:0] b,
                                        input logic [31:0] a, input logic ap);
        pixel_in_t px;
        px.action   = act;
        px.red      = r;
        px.green    = g;
        px.blue     = b;
        px.alpha    = a;
        px.alpha_on = ap;
        return px;
    endfunction

    function automatic logic [31:0] rand_float_bits();
        int sel;
        sel = $urandom_range(0, 15);
        if (sel <= 8) begin
            return {1'b0, 8'($urandom_range(100, 126)), 23'($urandom)};
        end else if (sel <= 10) begin
            return {1'b0, 8'($urandom_range(0, 99)), 23'($urandom)};
        end else if (sel == 11) begin
            return corner_bits[$urandom_range(0, 10)];
        end else if (sel <= 13) begin
            return $urandom;
        end else if (sel == 14) begin
            return {1'b1, 31'($urandom)};
        end
        return {1'b0, 8'($urandom_range(127, 255)), 23'($urandom)};
    endfunction

    function automatic pixel_in_t rand_pixel();
        if ($urandom_range(0, 99) < 30) begin
            return mk_px(ACT_REENC, $urandom, $urandom, $urandom, $urandom,
                         1'($urandom));
        end
        return mk_px(ACT_PACK, rand_float_bits(), rand_float_bits(), rand_float_bits(),
                     rand_float_bits(), 1'($urandom_range(0, 3) != 0));
    endfunction

    task automatic queue_corners();
        pending_q.push_back(mk_px(ACT_PACK, 32'h0000_0000, 32'h8000_0000, 32'h7F80_0000,
                                  32'h7FC0_0000, 1'b1));
        pending_q.push_back(mk_px(ACT_PACK, 32'h3F80_0000, 32'h3F00_0000, 32'h0000_0001,
                                  32'hFF80_0000, 1'b1));
        pending_q.push_back(mk_px(ACT_PACK, 32'h3B4D_2E1C, 32'h3B4D_2E1D, 32'h3B4D_2E1B,
                                  32'h3F7F_FFFF, 1'b1));
        pending_q.push_back(mk_px(ACT_PACK, 32'h3F7F_FFFF, 32'h4000_0000, 32'h007F_FFFF,
                                  32'h3F00_0000, 1'b0));
        pending_q.push_back(mk_px(ACT_PACK, 32'hBF00_0000, 32'h7F7F_FFFF, 32'hFFC0_0000,
                                  32'h0080_0000, 1'b1));
        pending_q.push_back(mk_px(ACT_PACK, 32'h7F80_0001, 32'h0080_0000, 32'h3B00_8081,
                                  32'h3B00_8080, 1'b1));
        pending_q.push_back(mk_px(ACT_PACK, 32'hFFFF_FFFF, 32'h3C23_D70A, 32'h3E80_0000,
                                  32'hFFFF_FFFF, 1'b0));
        pending_q.push_back(mk_px(ACT_REENC, 32'h0000_0000, 32'h0000_000A, 32'h0000_000B,
                                  32'h0000_0000, 1'b0));
        pending_q.push_back(mk_px(ACT_REENC, 32'h0000_00FF, 32'hFFFF_FF0A, 32'h0000_0001,
                                  32'hFFFF_FF7E, 1'b1));
        pending_q.push_back(mk_px(ACT_REENC, 32'hFFFF_FF00, 32'h0000_0080, 32'h1234_56FE,
                                  32'h0000_00FF, 1'b0));
        pending_q.push_back(mk_px(ACT_PACK, 32'h3F80_0001, 32'h3D4C_CCCD, 32'h3A80_0000,
                                  32'h3F80_0000, 1'b1));
        pending_q.push_back(mk_px(ACT_REENC, 32'h0000_000C, 32'h0000_0009, 32'h0000_00FE,
                                  32'h8000_0055, 1'b1));
    endtask

    task automatic wait_idle();
        while (pending_q.size() != 0 || i_start || expected_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_target(input logic tgt);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= tgt;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        srgb_mirror = tgt;
    endtask

    task automatic check_byte(input string name, input t_byte exp_val, input t_byte act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s expected %02h actual %02h", $time, name, exp_val, act_val);
            fails++;
        end
    endtask

    // driver: hold the beat until taken, then advance or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                expected_q.push_back(predict_pixel(drv_px, srgb_mirror));
            end
            if (!i_start || !o_busy) begin
                if (pending_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    drv_px = pending_q.pop_front();
                    i_action        <= drv_px.action;
                    i_red_in        <= drv_px.red;
                    i_green_in      <= drv_px.green;
                    i_blue_in       <= drv_px.blue;
                    i_alpha_in      <= drv_px.alpha;
                    i_alpha_present <= drv_px.alpha_on;
                    i_start         <= 1'b1;
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_q.size() == 0) begin
                $display("%0t: result beat with none expected: %02h %02h %02h %02h", $time,
                         o_red_out, o_green_out, o_blue_out, o_alpha_out);
                fails++;
            end else begin
                want = expected_q.pop_front();
                check_byte("red_out", want.red, o_red_out);
                check_byte("green_out", want.green, o_green_out);
                check_byte("blue_out", want.blue, o_blue_out);
                check_byte("alpha_out", want.alpha, o_alpha_out);
            end
        end
        if ((i_start && !o_busy) || o_done) begin
            stall_cnt = 0;
        end else begin
            stall_cnt++;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("srgb_linear_color_packer test failed");
                $finish;
            end
        end
    end

    initial begin
        c53805_pow12 = wpow(wide_t'(53805), 12);
        for (int k = 0; k < N_LVL; k++) begin
            knee_pow12[k] = wpow(wide_t'(200 * k + 2705), 12);
        end
        for (int b = 0; b < N_LVL; b++) begin
            srgb_to_lin_tab[b] = srgb_byte_decode(b);
            lin_to_srgb_tab[b] = (b == 0) ? t_byte'(0) : curve_byte(wide_t'(b), wide_t'(255), 0);
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int t = 0; t < 2; t++) begin
            wait_idle();
            write_target(t[0]);
            idle_pct = 0;
            queue_corners();
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_idle();
            write_target(phase_tgt[ph]);
            idle_pct = phase_idle[ph];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pending_q.push_back(rand_pixel());
            end
        end

        wait_idle();
        if (fails == 0) begin
            $display("srgb_linear_color_packer test passed");
        end else begin
            $display("srgb_linear_color_packer test failed");
        end
        $finish;
    end

endmodule
